@@ src/iss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants and types of the integer set sorter.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int MAX_ELEMS  = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int CNT_W      = $clog2(MAX_ELEMS + 1);
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // one classified beat handed from front to back
    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] value;
        logic                         last;
        logic                         keep;  // element fits in the store
        logic                         ovf;   // set lost an element so far
    } iss_entry_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_SORT,
        BK_EMIT
    } iss_back_state_t;

endpackage

@@ src/iss_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_in_if
// Input stream: one set element per beat, last closes the set.
// ----------------------------------------------------------------------------
interface iss_in_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [iss_pkg::ELEM_WIDTH-1:0] value;
    logic                                 last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

@@ src/iss_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_out_if
// Output stream: one sorted element per beat.
// ----------------------------------------------------------------------------
interface iss_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [iss_pkg::ELEM_WIDTH-1:0] sorted_value;
    logic                                 end_of_set;
    logic                                 overflowed;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflowed, output ready);

endinterface

@@ src/iss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_front
// Accepts input beats, counts the set and marks elements beyond capacity.
// ----------------------------------------------------------------------------
module iss_front (
    input  logic                clk,
    input  logic                rst_n,
    iss_in_if.sink              in_stream,
    input  logic                q_full,
    output logic                q_push,
    output iss_pkg::iss_entry_t q_entry
);
    import iss_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             keep;
    logic             accept;

    assign in_stream.ready = !q_full;
    assign accept          = in_stream.valid && !q_full;
    assign keep            = (cnt_reg < CNT_W'(MAX_ELEMS));

    always_comb
    begin
        q_push        = accept;
        q_entry.value = in_stream.value;
        q_entry.last  = in_stream.last;
        q_entry.keep  = keep;
        q_entry.ovf   = ovf_reg || !keep;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (in_stream.last)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(keep);
                ovf_next = ovf_reg || !keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

@@ src/iss_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_queue
// Short FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module iss_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  iss_pkg::iss_entry_t wr_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output iss_pkg::iss_entry_t rd_entry
);
    import iss_pkg::*;

    iss_entry_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

@@ src/iss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_back
// Loads the cell row, sorts it by odd-even transposition and streams it out.
// ----------------------------------------------------------------------------
module iss_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                q_not_empty,
    input  iss_pkg::iss_entry_t q_entry,
    output logic                q_pop,
    iss_out_if.source           out_stream
);
    import iss_pkg::*;

    iss_back_state_t state_reg, state_next;

    logic signed [ELEM_WIDTH-1:0] cell_reg  [MAX_ELEMS];
    logic signed [ELEM_WIDTH-1:0] cell_next [MAX_ELEMS];

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic             desc_cfg_reg;
    logic             desc_reg, desc_next;
    logic             set_ovf_reg, set_ovf_next;

    logic                         ov_reg, ov_next;
    logic signed [ELEM_WIDTH-1:0] od_value_reg, od_value_next;
    logic                         od_end_reg, od_end_next;
    logic                         od_ovf_reg, od_ovf_next;

    logic slot_free;
    logic sort_done;

    assign slot_free = !ov_reg || out_stream.ready;
    assign sort_done = (pass_reg == cnt_reg - 1'b1);

    assign out_stream.valid        = ov_reg;
    assign out_stream.sorted_value = od_value_reg;
    assign out_stream.end_of_set   = od_end_reg;
    assign out_stream.overflowed   = od_ovf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD:
                if (q_not_empty && q_entry.last)
                    state_next = BK_SORT;
            BK_SORT:
                if (sort_done)
                    state_next = BK_EMIT;
            BK_EMIT:
                if (slot_free && cnt_reg == CNT_W'(1))
                    state_next = BK_LOAD;
            default:
                state_next = BK_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop         = 1'b0;
        cnt_next      = cnt_reg;
        pass_next     = pass_reg;
        desc_next     = desc_reg;
        set_ovf_next  = set_ovf_reg;
        ov_next       = ov_reg && !out_stream.ready;
        od_value_next = od_value_reg;
        od_end_next   = od_end_reg;
        od_ovf_next   = od_ovf_reg;
        for (int k = 0; k < MAX_ELEMS; k++)
            cell_next[k] = cell_reg[k];

        case (state_reg)
            BK_LOAD:
            begin
                q_pop = q_not_empty;
                if (q_not_empty)
                begin
                    if (q_entry.keep)
                    begin
                        for (int k = 0; k < MAX_ELEMS; k++)
                            if (CNT_W'(k) == cnt_reg)
                                cell_next[k] = q_entry.value;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (q_entry.last)
                    begin
                        desc_next    = desc_cfg_reg;
                        set_ovf_next = q_entry.ovf;
                        pass_next    = '0;
                    end
                end
            end
            BK_SORT:
            begin
                // pairs of one parity per pass, disjoint, strict compare keeps ties stable
                for (int k = 0; k < MAX_ELEMS - 1; k++)
                begin
                    if ((1'(k) == pass_reg[0]) && (CNT_W'(k + 1) < cnt_reg))
                    begin
                        if (desc_reg ? (cell_reg[k] < cell_reg[k+1])
                                     : (cell_reg[k] > cell_reg[k+1]))
                        begin
                            cell_next[k]   = cell_reg[k+1];
                            cell_next[k+1] = cell_reg[k];
                        end
                    end
                end
                pass_next = pass_reg + 1'b1;
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next       = 1'b1;
                    od_value_next = cell_reg[0];
                    od_end_next   = (cnt_reg == CNT_W'(1));
                    od_ovf_next   = set_ovf_reg;
                    for (int k = 0; k < MAX_ELEMS - 1; k++)
                        cell_next[k] = cell_reg[k+1];
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_LOAD;
            cnt_reg      <= '0;
            pass_reg     <= '0;
            desc_cfg_reg <= 1'b0;
            desc_reg     <= 1'b0;
            set_ovf_reg  <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pass_reg    <= pass_next;
            desc_reg    <= desc_next;
            set_ovf_reg <= set_ovf_next;
            ov_reg      <= ov_next;
            if (cfg_we)
                desc_cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        od_value_reg <= od_value_next;
        od_end_reg   <= od_end_next;
        od_ovf_reg   <= od_ovf_next;
        for (int k = 0; k < MAX_ELEMS; k++)
            cell_reg[k] <= cell_next[k];
    end

endmodule

@@ src/integer_set_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_sorter
// Collects a set of signed integers and emits it sorted, one per beat.
// ----------------------------------------------------------------------------
// The front takes one input beat per cycle while its two-entry queue has room
// and marks elements past the 64-entry capacity as dropped. The back drains the
// queue one beat per cycle into a row of cells while it loads; on the beat that
// closes a set of N held elements it runs N odd-even transposition passes over
// the row, one per cycle, then shifts the set out at one beat per cycle while
// the output takes it. The single cell row loads, sorts and emits in turn, so
// the back takes no beat of a new set until the old set has left; the
// queue lets the front take up to two more beats while the back sorts or emits.
// Order is taken from the bit last written through cfg_we and cfg_wdata as it
// stands when the closing beat reaches the back; equal values leave in arrival
// order. There is no clearing pass after reset.
module integer_set_sorter (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  logic   cfg_wdata,
    iss_in_if.sink     in_stream,
    iss_out_if.source  out_stream
);
    import iss_pkg::*;

    iss_entry_t push_entry;
    iss_entry_t head_entry;
    logic       push;
    logic       q_full;
    logic       pop;
    logic       q_not_empty;

    iss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .q_full    (q_full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    iss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (push_entry),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rd_entry  (head_entry)
    );

    iss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_not_empty (q_not_empty),
        .q_entry     (head_entry),
        .q_pop       (pop),
        .out_stream  (out_stream)
    );

endmodule
